// ===== sv/efi_pkg.sv =====
package efi_pkg;

  // buffer layout
  localparam int RingHeaderBytes = 8;
  localparam int FragHeaderBytes = 20;
  localparam int HdrWords        = FragHeaderBytes / 2;
  localparam int SizeWord        = RingHeaderBytes / 2;
  localparam int ZeroSizeBytes   = 6;

  // position of the body-header size word and the saturated "in body" position
  localparam int SizePos = HdrWords + SizeWord;
  localparam int PosSat  = SizePos + 1;
  localparam int PosW    = $clog2(PosSat + 1);
  localparam int HdrIdxW = $clog2(HdrWords);

  // packed output data width, padded to whole bytes
  localparam int DataW = 224;

  // result kinds
  localparam logic [1:0] KindRecord  = 2'd0;
  localparam logic [1:0] KindEmpty   = 2'd1;
  localparam logic [1:0] KindOverrun = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic        buffer_end;
    logic [63:0] stamp;
    logic [31:0] source_id;
    logic [31:0] payload_bytes;
    logic [31:0] barrier_word;
    logic [30:0] item_header_offset;
    logic [30:0] item_body_offset;
  } result_t;

endpackage

// ===== sv/efi_out_buf.sv =====
module efi_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  efi_pkg::result_t res_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             take_i,
  output efi_pkg::result_t res_o
);
  import efi_pkg::*;

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    take;

  assign take    = out_valid_q && take_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;

  // control: output slot plus one skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (push_i) begin
        if (out_valid_q && !take) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !take) begin
        skid_q <= res_i;
      end else begin
        out_q <= res_i;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full while output slot empty");

  a_skid_drains_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && take |=> out_valid_q && !skid_valid_q)
    else $error("skid slot not moved to output on take");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !take_i |=> out_valid_q && $stable(out_q))
    else $error("waiting result changed before it was taken");

endmodule

// ===== sv/event_fragment_indexer.sv =====
// Event fragment indexer: takes one 16-bit word per cycle from a stream of buffers, each
// opening with a 32-bit byte count (low word first), and indexes the fragments inside.
// One result is produced per fragment (on its body-header size word, or on header word 9
// when the body is too short to hold it), one per empty buffer, and one overrun error per
// truncated buffer, after which the rest of that buffer is skipped. Throughput is one word
// per clock: every word is handled in the cycle it is accepted, updating the parser
// registers and loading the result or skid register. A one-entry skid stage behind the
// result register keeps input flowing while a result waits; input stalls only when both
// the result register and the skid stage are full. No clearing pass is needed after reset.
module event_fragment_indexer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // word[15:0]
  input  logic [15:0]               s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // stamp[63:0], source_id[95:64], payload_bytes[127:96], barrier_word[159:128],
  // item_header_offset[190:160], item_body_offset[221:191], zeros[223:222]
  output logic [efi_pkg::DataW-1:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]                m_axis_tuser,
  // buffer_end
  output logic                      m_axis_tlast
);
  import efi_pkg::*;

  localparam logic [1:0] PhLenLo   = 2'd0;
  localparam logic [1:0] PhLenHi   = 2'd1;
  localparam logic [1:0] PhFrag    = 2'd2;
  localparam logic [1:0] PhDiscard = 2'd3;

  logic [1:0]      phase_q, phase_d;
  logic [15:0]     len_lo_q, len_lo_d;
  logic [30:0]     words_left_q, words_left_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [30:0]     body_left_q, body_left_d;
  logic [30:0]     frag_body_q, frag_body_d;
  logic [30:0]     hdr_off_q, hdr_off_d;
  logic [15:0]     hdr_q [HdrWords];
  logic [15:0]     hdr_cur [HdrWords];

  logic        accept;
  logic [15:0] w;
  logic [31:0] count;
  logic [30:0] wl_dec;
  logic [30:0] body_cur;
  logic        fr_err;
  logic        fr_end;
  logic [15:0] size_word;
  logic [15:0] size_eff;
  logic [16:0] size_sum;
  result_t     rec;
  result_t     res;
  logic        res_valid;
  result_t     out_res;
  logic        buf_ready;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = buf_ready;
  assign w             = s_axis_tdata;
  assign count         = {w, len_lo_q};
  assign wl_dec        = words_left_q - 31'd1;

  // header words with the current word folded in
  always_comb begin
    hdr_cur = hdr_q;
    if (pos_q < PosW'(HdrWords)) begin
      hdr_cur[pos_q[HdrIdxW-1:0]] = w;
    end
  end

  // fragment body length in words: payload bytes / 2
  assign body_cur = {hdr_cur[7], hdr_cur[6][15:1]};

  // fragment record built from the header and the ring item offsets
  assign size_word = (pos_q == PosW'(SizePos)) ? w : 16'd0;
  assign size_eff  = (size_word == 16'd0) ? 16'(ZeroSizeBytes) : size_word;
  assign size_sum  = 17'(RingHeaderBytes) + {1'b0, size_eff};

  always_comb begin
    rec                    = '0;
    rec.kind               = KindRecord;
    rec.stamp              = {hdr_cur[3], hdr_cur[2], hdr_cur[1], hdr_cur[0]};
    rec.source_id          = {hdr_cur[5], hdr_cur[4]};
    rec.payload_bytes      = {hdr_cur[7], hdr_cur[6]};
    rec.barrier_word       = {hdr_cur[9], hdr_cur[8]};
    rec.item_header_offset = hdr_off_q;
    rec.item_body_offset   = hdr_off_q + {15'd0, size_sum[16:1]};
  end

  // word parser
  always_comb begin
    phase_d      = phase_q;
    len_lo_d     = len_lo_q;
    words_left_d = words_left_q;
    pos_d        = pos_q;
    body_left_d  = body_left_q;
    frag_body_d  = frag_body_q;
    hdr_off_d    = hdr_off_q;
    res          = '0;
    res_valid    = 1'b0;
    fr_err       = 1'b0;
    fr_end       = 1'b0;
    if (accept) begin
      case (phase_q)
        PhLenLo: begin
          len_lo_d = w;
          phase_d  = PhLenHi;
        end
        PhLenHi: begin
          words_left_d = (count[31:2] == 30'd0) ? 31'd0 : count[31:1] - 31'd2;
          pos_d        = '0;
          hdr_off_d    = 31'(HdrWords);
          if (count[31:2] == 30'd0 || count[31:1] == 31'd2) begin
            res_valid      = 1'b1;
            res.kind       = KindEmpty;
            res.buffer_end = 1'b1;
            phase_d        = PhLenLo;
          end else begin
            phase_d = PhFrag;
          end
        end
        PhDiscard: begin
          if (words_left_q != 31'd0) begin
            words_left_d = wl_dec;
          end
          if (words_left_q <= 31'd1) begin
            phase_d = PhLenLo;
          end
        end
        PhFrag: begin
          words_left_d = wl_dec;
          if (pos_q == '0 && words_left_q < 31'(HdrWords)) begin
            fr_err = 1'b1;
          end else if (pos_q == PosW'(HdrWords - 1)) begin
            // last header word: fragment length known
            if (body_cur > wl_dec) begin
              fr_err = 1'b1;
            end else begin
              frag_body_d = body_cur;
              body_left_d = body_cur;
              fr_end      = (body_cur == 31'd0);
              if (body_cur <= 31'(SizeWord)) begin
                res_valid      = 1'b1;
                res            = rec;
                res.buffer_end = (wl_dec == body_cur);
              end
            end
          end else if (pos_q >= PosW'(HdrWords)) begin
            body_left_d = body_left_q - 31'd1;
            fr_end      = (body_left_q == 31'd1);
            if (pos_q == PosW'(SizePos)) begin
              res_valid      = 1'b1;
              res            = rec;
              res.buffer_end = (words_left_q == body_left_q);
            end
          end
          if (fr_err) begin
            res_valid      = 1'b1;
            res            = '0;
            res.kind       = KindOverrun;
            res.buffer_end = 1'b1;
            pos_d          = '0;
            phase_d        = (wl_dec != 31'd0) ? PhDiscard : PhLenLo;
          end else begin
            if (fr_end) begin
              hdr_off_d = hdr_off_q + 31'(HdrWords)
                        + ((pos_q == PosW'(HdrWords - 1)) ? 31'd0 : frag_body_q);
              pos_d     = '0;
            end else if (pos_q != PosW'(PosSat)) begin
              pos_d = pos_q + PosW'(1);
            end
            if (wl_dec == 31'd0) begin
              phase_d = PhLenLo;
              pos_d   = '0;
            end
          end
        end
        default: begin
          phase_d = PhLenLo;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhLenLo;
      len_lo_q     <= '0;
      words_left_q <= '0;
      pos_q        <= '0;
      body_left_q  <= '0;
      frag_body_q  <= '0;
      hdr_off_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      len_lo_q     <= len_lo_d;
      words_left_q <= words_left_d;
      pos_q        <= pos_d;
      body_left_q  <= body_left_d;
      frag_body_q  <= frag_body_d;
      hdr_off_q    <= hdr_off_d;
    end
  end

  // header word capture
  always_ff @(posedge clk_i) begin
    if (accept && phase_q == PhFrag) begin
      hdr_q <= hdr_cur;
    end
  end

  // result register and skid stage
  efi_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .res_i   (res),
    .ready_o (buf_ready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {2'b00, out_res.item_body_offset, out_res.item_header_offset,
                         out_res.barrier_word, out_res.payload_bytes, out_res.source_id,
                         out_res.stamp};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.buffer_end;

  a_frag_has_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhFrag |-> words_left_q != 31'd0)
    else $error("fragment phase with no buffer words left");

  a_discard_has_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDiscard |-> words_left_q != 31'd0)
    else $error("discard phase with no buffer words left");

  a_pos_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhFrag |-> pos_q == '0)
    else $error("fragment position not cleared outside fragment phase");

  a_end_kinds_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.kind != KindRecord |-> res.buffer_end)
    else $error("empty or overrun result does not close the buffer");

  a_err_leaves_frag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.kind == KindOverrun |=> phase_q != PhFrag)
    else $error("parser stayed in fragment phase after overrun");

endmodule
